// ===== hdl/fsfl_pkg.sv =====
// Shared types and constants for the fixed-size free-list allocator.
// No dependencies; imported by fsfl_div and the top level.
package fsfl_pkg;

    localparam int SLAB_BYTES = 65536;
    localparam int OFS_W      = $clog2(SLAB_BYTES);
    localparam int END_W      = OFS_W + 1;
    localparam int CFG_W      = 17;
    localparam int SZ_W       = CFG_W + 1;
    localparam int CNT_W      = 14;
    localparam int GRAN_SH    = 3;
    localparam int LINK_DEPTH = SLAB_BYTES / 8;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);
    localparam int LINK_W     = OFS_W + 1;

    localparam logic [END_W-1:0] SLAB_END  = END_W'(SLAB_BYTES);
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [CFG_W-1:0] SLOT_MIN  = CFG_W'(8);
    localparam logic [SZ_W-1:0]  SLOT_RND  = SZ_W'(7);

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] STS_DONE  = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_RANGE = 2'd2;

    typedef struct packed {
        logic             command;
        logic [OFS_W-1:0] release_offset;
    } t_in_beat;

    typedef struct packed {
        logic [OFS_W-1:0] slot_offset;
        logic [1:0]       status;
        logic [CNT_W-1:0] slots_free;
    } t_out_beat;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] quot;
        logic [SZ_W-1:0]  rem;
    } t_div_res;

endpackage

// ===== hdl/fixed_size_free_list_allocator.sv =====
// Fixed-size slot pool allocator: LIFO free list in a link RAM plus a bump mark.
// Depends on fsfl_pkg, fsfl_ram and fsfl_div.
//
// A release, an allocate served from the bump mark and a failed allocate go straight
// to the output register; a free-list allocate first waits in a pop state for the
// registered link RAM read at the list head. A result sits in an output register,
// and a new item is taken once that register is free or being drained and the
// block is idle. A write to the size register restarts the pool and runs a
// bit-serial division of the region size by the slot size: input is stalled and
// the config port is not ready until the division is done. Input is also stalled
// while a size write is offered. The link RAM is not cleared after reset.
module fixed_size_free_list_allocator
    import fsfl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  t_in_beat         i_in_data,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out_beat        o_out_data,
    input  logic             i_out_stall,
    input  logic             i_cfg_valid,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_cfg_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SIZE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic             r_head_valid, n_head_valid;
    logic [OFS_W-1:0] r_head, n_head;
    logic [END_W-1:0] r_mark, n_mark;
    logic [END_W-1:0] r_pool_end, n_pool_end;
    logic [END_W-1:0] r_step, n_step;
    logic [CNT_W-1:0] r_free, n_free;
    logic             r_out_valid, n_out_valid;
    t_out_beat        r_out, n_out;

    logic             out_free;
    logic             in_acc;
    logic             cfg_acc;
    logic             rel_bad;
    logic             ram_we, ram_re;
    logic [LINK_W-1:0] ram_rdata;
    logic [CFG_W-1:0] cfg_min;
    logic [SZ_W-1:0]  cfg_size;
    t_div_res         div_res;

    assign out_free    = !r_out_valid || !i_out_stall;
    // a pending size write takes the edge, so the request beat waits
    assign o_in_stall  = (r_state != S_IDLE) || !out_free || i_cfg_valid;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign rel_bad     = {1'b0, i_in_data.release_offset} >= r_pool_end;

    assign cfg_min  = (i_cfg_data < SLOT_MIN) ? SLOT_MIN : i_cfg_data;
    assign cfg_size = ({1'b0, cfg_min} + SLOT_RND) & ~SLOT_RND;

    assign ram_we = in_acc && (i_in_data.command == CMD_RELEASE) && !rel_bad;
    assign ram_re = in_acc && (i_in_data.command == CMD_ALLOC) && r_head_valid;

    fsfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (LINK_DEPTH)
    ) u_link (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in_data.release_offset[OFS_W-1 -: LINK_AW]),
        .i_wdata ({r_head_valid, r_head}),
        .i_re    (ram_re),
        .i_raddr (r_head[OFS_W-1 -: LINK_AW]),
        .o_rdata (ram_rdata)
    );

    fsfl_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cfg_acc),
        .i_divisor (cfg_size),
        .o_res     (div_res)
    );

    always_comb begin
        n_state      = r_state;
        n_head_valid = r_head_valid;
        n_head       = r_head;
        n_mark       = r_mark;
        n_pool_end   = r_pool_end;
        n_step       = r_step;
        n_free       = r_free;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;

        case (r_state)
            S_IDLE: begin
                if (cfg_acc) begin
                    n_state      = S_SIZE;
                    n_head_valid = 1'b0;
                    n_head       = '0;
                    n_mark       = '0;
                    n_step       = cfg_size[END_W-1:0];
                end else if (in_acc) begin
                    n_out.slot_offset = '0;
                    n_out.status      = STS_DONE;
                    if (i_in_data.command == CMD_RELEASE) begin
                        if (rel_bad) begin
                            n_out.status = STS_RANGE;
                        end else begin
                            n_head       = i_in_data.release_offset;
                            n_head_valid = 1'b1;
                            if (r_free != COUNT_MAX) begin
                                n_free = r_free + CNT_W'(1);
                            end
                        end
                        n_out_valid = 1'b1;
                    end else if (r_head_valid) begin
                        // result goes out from the pop state once the link read returns and the output is free
                        n_out.slot_offset = r_head;
                        n_state           = S_POP;
                        if (r_free != '0) begin
                            n_free = r_free - CNT_W'(1);
                        end
                    end else if (r_mark < r_pool_end) begin
                        n_out.slot_offset = r_mark[OFS_W-1:0];
                        n_mark            = END_W'(r_mark + r_step);
                        if (r_free != '0) begin
                            n_free = r_free - CNT_W'(1);
                        end
                        n_out_valid = 1'b1;
                    end else begin
                        n_out.status = STS_EMPTY;
                        n_out_valid  = 1'b1;
                    end
                    n_out.slots_free = n_free;
                end
            end
            S_POP: begin
                if (out_free) begin
                    n_head       = ram_rdata[OFS_W-1:0];
                    n_head_valid = ram_rdata[LINK_W-1];
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SIZE: begin
                if (div_res.done) begin
                    n_pool_end = END_W'(SLAB_END - div_res.rem[END_W-1:0]);
                    n_free     = div_res.quot;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head_valid <= 1'b0;
            r_head       <= '0;
            r_mark       <= '0;
            r_pool_end   <= SLAB_END;
            r_step       <= END_W'(8);
            r_free       <= CNT_W'(SLAB_BYTES / 8);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head_valid <= n_head_valid;
            r_head       <= n_head;
            r_mark       <= n_mark;
            r_pool_end   <= n_pool_end;
            r_step       <= n_step;
            r_free       <= n_free;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an in-range release always leaves a valid list head
    a_release_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_head_valid)
        else $error("list head not valid after release");

    // every accepted item leaves a pending result or a pop in flight
    a_item_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_POP) || r_out_valid)
        else $error("accepted item produced no result");

    // the bump mark never passes the end of the pool
    a_mark_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mark <= r_pool_end)
        else $error("untouched mark beyond pool end");

    // a pop waits on the link read and blocks further input
    a_pop_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> o_in_stall && !o_cfg_ready)
        else $error("input taken during free-list pop");

endmodule

// ===== hdl/fsfl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fsfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/fsfl_div.sv =====
// Bit-serial restoring divider: SLAB_BYTES / slot size, one quotient bit per cycle.
// Depends on fsfl_pkg.
module fsfl_div
    import fsfl_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [SZ_W-1:0] i_divisor,
    output t_div_res        o_res
);

    localparam int STEP_W = $clog2(END_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [SZ_W-1:0]   r_div;
    logic [SZ_W-1:0]   r_rem;
    logic [END_W-1:0]  r_quot;
    logic [SZ_W:0]     rem_sh;
    logic              take;

    assign rem_sh = {r_rem, SLAB_END[r_cnt]};
    assign take   = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(END_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= take ? SZ_W'(rem_sh - {1'b0, r_div}) : rem_sh[SZ_W-1:0];
            r_quot <= {r_quot[END_W-2:0], take};
        end
    end

    // slot size is at least 8, so the quotient fits the count width
    assign o_res.done = r_done;
    assign o_res.quot = r_quot[CNT_W-1:0];
    assign o_res.rem  = r_rem;

endmodule
